[src/otm_pkg.sv]
// ----------------------------------------------------------------------------
// otm_pkg
// Types, command codes, register indexes and the temperature read sequence
// for the one-wire temperature master.
// ----------------------------------------------------------------------------
package otm_pkg;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_GAP,
    PH_RST_PRES,
    PH_RST_POST,
    PH_WR_SLOT,
    PH_WR_REC,
    PH_RD_PRE,
    PH_RD_SLOT,
    PH_RD_REC
  } phase_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_RESET,
    OP_WRITE,
    OP_READ
  } op_t;

  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_RESET = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_TEMP  = 3'd4;

  localparam int CMD_WIDTH   = 3;
  localparam int BYTE_WIDTH  = 8;
  localparam int TEMP_WIDTH  = 16;
  localparam int CFG_WIDTH   = 10;
  localparam int INDEX_WIDTH = 3;

  localparam logic [2:0] REG_RESET_LOW      = 3'd0;
  localparam logic [2:0] REG_PRESENCE_DELAY = 3'd1;
  localparam logic [2:0] REG_POST_PRESENCE  = 3'd2;
  localparam logic [2:0] REG_SLOT_LOW       = 3'd3;
  localparam logic [2:0] REG_WRITE_SLOT     = 3'd4;
  localparam logic [2:0] REG_READ_SAMPLE    = 3'd5;
  localparam logic [2:0] REG_READ_SLOT      = 3'd6;
  localparam logic [2:0] REG_RECOVERY       = 3'd7;

  localparam logic [9:0] RST_RESET_LOW      = 10'd504;
  localparam logic [9:0] RST_PRESENCE_DELAY = 10'd32;
  localparam logic [9:0] RST_POST_PRESENCE  = 10'd128;
  localparam logic [9:0] RST_SLOT_LOW       = 10'd8;
  localparam logic [9:0] RST_WRITE_SLOT     = 10'd72;
  localparam logic [9:0] RST_READ_SAMPLE    = 10'd12;
  localparam logic [9:0] RST_READ_SLOT      = 10'd76;
  localparam logic [9:0] RST_RECOVERY       = 10'd8;

  localparam logic [7:0] ROM_SKIP   = 8'hCC;
  localparam logic [7:0] CONVERT_T  = 8'h44;
  localparam logic [7:0] READ_PAD   = 8'hBE;
  localparam logic [7:0] SAMPLE_BIT = 8'h80;

  localparam logic [3:0] SEQ_NONE     = 4'd0;
  localparam logic [3:0] SEQ_FIRST    = 4'd1;
  localparam logic [3:0] SEQ_LOW_BYTE = 4'd7;
  localparam logic [3:0] SEQ_LAST     = 4'd9;

  function automatic op_t seq_kind(logic [3:0] step);
    op_t k;
    case (step)
      4'd1, 4'd4, 4'd9:        k = OP_RESET;
      4'd2, 4'd3, 4'd5, 4'd6:  k = OP_WRITE;
      4'd7, 4'd8:              k = OP_READ;
      default:                 k = OP_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] seq_data(logic [3:0] step);
    logic [7:0] d;
    case (step)
      4'd2, 4'd5: d = ROM_SKIP;
      4'd3:       d = CONVERT_T;
      4'd6:       d = READ_PAD;
      default:    d = 8'h00;
    endcase
    return d;
  endfunction

endpackage

[src/otm_ifs.sv]
// ----------------------------------------------------------------------------
// otm channel interfaces
// Tick input, status output and configuration write channels.
// ----------------------------------------------------------------------------
interface otm_tick_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] data_byte;
  logic       line_level;

  modport source (output valid, output command, output data_byte, output line_level,
                  input ready);
  modport sink   (input valid, input command, input data_byte, input line_level,
                  output ready);
endinterface

interface otm_status_if;
  logic        valid;
  logic        ready;
  logic        drive_low;
  logic        busy_res;
  logic        done_res;
  logic [7:0]  read_value;
  logic [15:0] temperature;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output read_value, output temperature, input ready);
  modport sink   (input valid, input drive_low, input busy_res, input done_res,
                  input read_value, input temperature, output ready);
endinterface

interface otm_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [9:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/one_wire_temperature_master.sv]
// ----------------------------------------------------------------------------
// one_wire_temperature_master
// One-wire bus master stepped by one tick item per bus microsecond; runs
// reset, byte write, byte read and the temperature read of two scratchpad bytes.
// ----------------------------------------------------------------------------
// The status of each tick transfer is registered in the result register.
// Throughput: one tick per cycle while not stalled; the bus state update is a
// single pass of logic from the state registers and the tick to the next state.
// Ready drops only while the result register is full and not taken.
// Reset: timing registers return to defaults, the bus master goes idle and
// the read byte and temperature word clear.
module one_wire_temperature_master #(
  parameter int COUNTER_WIDTH = 10
) (
  input  logic                clk,
  input  logic                rst,
  otm_tick_if.sink            tick,
  otm_status_if.source        status,
  otm_cfg_if.sink             cfg
);

  localparam int CMPW = ((COUNTER_WIDTH > otm_pkg::CFG_WIDTH) ?
                         COUNTER_WIDTH : otm_pkg::CFG_WIDTH) + 1;
  localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

  logic [9:0] reset_low_ticks, presence_delay_ticks, post_presence_ticks, slot_low_ticks;
  logic [9:0] write_slot_ticks, read_sample_ticks, read_slot_ticks, recovery_ticks;

  otm_pkg::phase_t            phase, phase_next;
  logic [COUNTER_WIDTH-1:0]   tick_count, tick_count_next;
  logic [2:0]                 bit_index, bit_index_next;
  logic [7:0]                 shift_byte, shift_byte_next;
  logic [3:0]                 sequence_step, sequence_step_next;
  logic [7:0]                 low_byte, low_byte_next;
  logic [15:0]                result_word, result_word_next;
  logic [7:0]                 last_read, last_read_next;
  logic                       drive_next, done_next;

  logic        out_valid;
  logic        out_drive, out_busy, out_done;
  logic [7:0]  out_read;
  logic [15:0] out_temp;
  logic        accept;

  assign cfg.ready  = 1'b1;
  assign tick.ready = !out_valid || status.ready;
  assign accept     = tick.valid && tick.ready;

  assign status.valid       = out_valid;
  assign status.drive_low   = out_drive;
  assign status.busy_res    = out_busy;
  assign status.done_res    = out_done;
  assign status.read_value  = out_read;
  assign status.temperature = out_temp;

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_ticks      <= otm_pkg::RST_RESET_LOW;
      presence_delay_ticks <= otm_pkg::RST_PRESENCE_DELAY;
      post_presence_ticks  <= otm_pkg::RST_POST_PRESENCE;
      slot_low_ticks       <= otm_pkg::RST_SLOT_LOW;
      write_slot_ticks     <= otm_pkg::RST_WRITE_SLOT;
      read_sample_ticks    <= otm_pkg::RST_READ_SAMPLE;
      read_slot_ticks      <= otm_pkg::RST_READ_SLOT;
      recovery_ticks       <= otm_pkg::RST_RECOVERY;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        otm_pkg::REG_RESET_LOW:      reset_low_ticks      <= cfg.data;
        otm_pkg::REG_PRESENCE_DELAY: presence_delay_ticks <= cfg.data;
        otm_pkg::REG_POST_PRESENCE:  post_presence_ticks  <= cfg.data;
        otm_pkg::REG_SLOT_LOW:       slot_low_ticks       <= cfg.data;
        otm_pkg::REG_WRITE_SLOT:     write_slot_ticks     <= cfg.data;
        otm_pkg::REG_READ_SAMPLE:    read_sample_ticks    <= cfg.data;
        otm_pkg::REG_READ_SLOT:      read_slot_ticks      <= cfg.data;
        otm_pkg::REG_RECOVERY:       recovery_ticks       <= cfg.data;
        default: ;
      endcase
    end
  end

  function automatic logic ends(logic [COUNTER_WIDTH-1:0] tc, logic [9:0] dur);
    return ((CMPW'(tc) + CMPW'(1)) >= CMPW'(dur)) || (tc == CNT_MAX);
  endfunction

  always_comb begin
    otm_pkg::op_t    kind;
    logic [7:0]      kbyte;
    logic            go;
    logic            fin;
    logic            last;
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    sequence_step_next = sequence_step;
    low_byte_next      = low_byte;
    result_word_next   = result_word;
    last_read_next     = last_read;
    drive_next         = 1'b0;
    done_next          = 1'b0;
    fin                = 1'b0;
    last               = 1'b0;
    go                 = 1'b0;
    kind               = otm_pkg::OP_NONE;
    kbyte              = tick.data_byte;

    if (phase == otm_pkg::PH_IDLE) begin
      go = 1'b1;
      case (tick.command)
        otm_pkg::CMD_RESET: kind = otm_pkg::OP_RESET;
        otm_pkg::CMD_WRITE: kind = otm_pkg::OP_WRITE;
        otm_pkg::CMD_READ:  kind = otm_pkg::OP_READ;
        otm_pkg::CMD_TEMP: begin
          sequence_step_next = otm_pkg::SEQ_FIRST;
          kind  = otm_pkg::seq_kind(otm_pkg::SEQ_FIRST);
          kbyte = otm_pkg::seq_data(otm_pkg::SEQ_FIRST);
        end
        default: go = 1'b0;
      endcase
      if (go) begin
        tick_count_next = '0;
        bit_index_next  = '0;
        case (kind)
          otm_pkg::OP_RESET: phase_next = otm_pkg::PH_RST_LOW;
          otm_pkg::OP_WRITE: begin
            shift_byte_next = kbyte;
            phase_next      = otm_pkg::PH_WR_SLOT;
          end
          otm_pkg::OP_READ: begin
            shift_byte_next = '0;
            phase_next      = otm_pkg::PH_RD_PRE;
          end
          default: phase_next = otm_pkg::PH_IDLE;
        endcase
      end
    end

    case (phase_next)
      otm_pkg::PH_IDLE: ;
      otm_pkg::PH_RST_LOW: begin
        drive_next = 1'b1;
        last = ends(tick_count_next, reset_low_ticks);
        tick_count_next = last ? '0 : tick_count_next + 1'b1;
        if (last) phase_next = otm_pkg::PH_RST_GAP;
      end
      otm_pkg::PH_RST_GAP: begin
        last = ends(tick_count_next, presence_delay_ticks);
        tick_count_next = last ? '0 : tick_count_next + 1'b1;
        if (last) phase_next = otm_pkg::PH_RST_PRES;
      end
      otm_pkg::PH_RST_PRES: begin
        if (!tick.line_level) begin
          phase_next      = otm_pkg::PH_RST_POST;
          tick_count_next = '0;
        end
      end
      otm_pkg::PH_RST_POST: begin
        last = ends(tick_count_next, post_presence_ticks);
        tick_count_next = last ? '0 : tick_count_next + 1'b1;
        fin = last;
      end
      otm_pkg::PH_WR_SLOT: begin
        drive_next = (CMPW'(tick_count_next) < CMPW'(slot_low_ticks)) || !shift_byte_next[0];
        last = ends(tick_count_next, write_slot_ticks);
        tick_count_next = last ? '0 : tick_count_next + 1'b1;
        if (last) phase_next = otm_pkg::PH_WR_REC;
      end
      otm_pkg::PH_WR_REC: begin
        last = ends(tick_count_next, recovery_ticks);
        tick_count_next = last ? '0 : tick_count_next + 1'b1;
        if (last) begin
          shift_byte_next = shift_byte_next >> 1;
          bit_index_next  = bit_index_next + 1'b1;
          if (bit_index_next == '0) fin = 1'b1;
          else phase_next = otm_pkg::PH_WR_SLOT;
        end
      end
      otm_pkg::PH_RD_PRE: begin
        last = ends(tick_count_next, recovery_ticks);
        tick_count_next = last ? '0 : tick_count_next + 1'b1;
        if (last) phase_next = otm_pkg::PH_RD_SLOT;
      end
      otm_pkg::PH_RD_SLOT: begin
        if (tick_count_next == '0) shift_byte_next = shift_byte_next >> 1;
        drive_next = CMPW'(tick_count_next) < CMPW'(slot_low_ticks);
        if ((CMPW'(tick_count_next) == CMPW'(read_sample_ticks)) && tick.line_level)
          shift_byte_next = shift_byte_next | otm_pkg::SAMPLE_BIT;
        last = ends(tick_count_next, read_slot_ticks);
        tick_count_next = last ? '0 : tick_count_next + 1'b1;
        if (last) phase_next = otm_pkg::PH_RD_REC;
      end
      otm_pkg::PH_RD_REC: begin
        last = ends(tick_count_next, recovery_ticks);
        tick_count_next = last ? '0 : tick_count_next + 1'b1;
        if (last) begin
          bit_index_next = bit_index_next + 1'b1;
          if (bit_index_next == '0) begin
            last_read_next = shift_byte_next;
            fin = 1'b1;
          end else begin
            phase_next = otm_pkg::PH_RD_SLOT;
          end
        end
      end
      default: phase_next = otm_pkg::PH_IDLE;
    endcase

    if (fin) begin
      phase_next      = otm_pkg::PH_IDLE;
      tick_count_next = '0;
      if (sequence_step_next == otm_pkg::SEQ_NONE) begin
        done_next = 1'b1;
      end else begin
        if (sequence_step_next == otm_pkg::SEQ_LOW_BYTE) low_byte_next = last_read_next;
        if (sequence_step_next >= otm_pkg::SEQ_LAST) begin
          result_word_next   = {last_read_next, low_byte_next};
          sequence_step_next = otm_pkg::SEQ_NONE;
          done_next          = 1'b1;
        end else begin
          sequence_step_next = sequence_step_next + 1'b1;
          tick_count_next    = '0;
          bit_index_next     = '0;
          case (otm_pkg::seq_kind(sequence_step_next))
            otm_pkg::OP_RESET: phase_next = otm_pkg::PH_RST_LOW;
            otm_pkg::OP_WRITE: begin
              shift_byte_next = otm_pkg::seq_data(sequence_step_next);
              phase_next      = otm_pkg::PH_WR_SLOT;
            end
            otm_pkg::OP_READ: begin
              shift_byte_next = '0;
              phase_next      = otm_pkg::PH_RD_PRE;
            end
            default: phase_next = otm_pkg::PH_IDLE;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= otm_pkg::PH_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      sequence_step <= otm_pkg::SEQ_NONE;
      low_byte      <= '0;
      result_word   <= '0;
      last_read     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        tick_count    <= tick_count_next;
        bit_index     <= bit_index_next;
        shift_byte    <= shift_byte_next;
        sequence_step <= sequence_step_next;
        low_byte      <= low_byte_next;
        result_word   <= result_word_next;
        last_read     <= last_read_next;
        out_valid     <= 1'b1;
      end else if (status.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_drive <= drive_next;
      out_busy  <= (phase_next != otm_pkg::PH_IDLE);
      out_done  <= done_next;
      out_read  <= last_read_next;
      out_temp  <= result_word_next;
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    status.valid && status.done_res |-> !status.busy_res)
    else $error("done reported while still busy");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    sequence_step <= otm_pkg::SEQ_LAST)
    else $error("sequence step out of range");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    phase == otm_pkg::PH_IDLE |-> tick_count == '0)
    else $error("tick count not cleared while idle");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(phase) && $stable(tick_count) && $stable(result_word))
    else $error("bus state moved without a tick transfer");

endmodule
